[sv/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, fixed-point constants, sector codes and the hue-path struct.
// ----------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

  // Fraction format: (1 << FRACTION_BITS) is 1.0
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned CHAN_W        = FRACTION_BITS + 1;
  localparam logic [CHAN_W-1:0] ONE_FIX = {1'b1, {FRACTION_BITS{1'b0}}};

  // Hue in 1/256 degree
  localparam int unsigned HUE_W      = 24;
  localparam int unsigned HUE_FULL   = 360 * 256;
  localparam int unsigned HUE_SECTOR = HUE_FULL / 6;
  localparam int unsigned HUE_DOUBLE = 2 * HUE_SECTOR;
  localparam int unsigned HM_W       = $clog2(HUE_FULL);
  localparam int unsigned WGT_W      = $clog2(HUE_SECTOR + 1);

  // Reciprocal for hue mod 360 degrees: quotient estimate is exact or one low
  localparam int unsigned HUE_SHIFT   = HUE_W + 8;
  localparam int unsigned HUE_RECIP_W = HUE_SHIFT - $clog2(HUE_FULL) + 1;
  localparam logic [HUE_RECIP_W-1:0] HUE_RECIP =
    HUE_RECIP_W'((64'd1 << HUE_SHIFT) / HUE_FULL);
  localparam int unsigned HUE_QUO_W   = HUE_W - $clog2(HUE_FULL) + 1;

  // Reciprocal for the divide by one sector width in the x path
  localparam int unsigned PROD_W      = CHAN_W + WGT_W;
  localparam int unsigned DIV_RECIP_W = PROD_W - $clog2(HUE_SECTOR) + 1;
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'((64'd1 << PROD_W) / HUE_SECTOR);

  // 60-degree sectors
  typedef enum logic [2:0] {
    SEC_RED_YELLOW   = 3'd0,
    SEC_YELLOW_GREEN = 3'd1,
    SEC_GREEN_CYAN   = 3'd2,
    SEC_CYAN_BLUE    = 3'd3,
    SEC_BLUE_MAGENTA = 3'd4,
    SEC_MAGENTA_RED  = 3'd5
  } sector_e;

  // Hue path result: sector and weight (distance, or sector width - distance in odd sectors)
  typedef struct packed {
    sector_e            sector;
    logic [WGT_W-1:0]   weight;
  } hue_info_t;

  // Saturate a fraction to 1.0
  function automatic logic [CHAN_W-1:0] clamp_one(input logic [CHAN_W-1:0] f);
    return (f > ONE_FIX) ? ONE_FIX : f;
  endfunction

endpackage

`default_nettype wire

[sv/hsv_to_rgb_converter.sv]
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Fixed-point hue/saturation/value to red/green/blue, fully pipelined.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle; busy_o stays low, every stage is a
//   free-running register with a valid bit alongside.
// Reset: asynchronous, active low; clears the valid pipeline only.
// The receiver cannot stall, so results leave on the strobe cycle.
`default_nettype none

module hsv_to_rgb_converter import hsvrgb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [HUE_W-1:0]  hue_i,
  input  wire logic [CHAN_W-1:0] saturation_i,
  input  wire logic [CHAN_W-1:0] brightness_i,
  output logic                   valid_o,
  output logic      [CHAN_W-1:0] red_o,
  output logic      [CHAN_W-1:0] green_o,
  output logic      [CHAN_W-1:0] blue_o
);

  localparam int unsigned DEPTH = 7;

  logic [DEPTH-1:0]    vld_d, vld_q;
  logic [CHAN_W-1:0]   s_cl, v_cl;
  logic [2*CHAN_W-1:0] p1_q;
  logic [CHAN_W-1:0]   v1_q, v2_q;
  logic [CHAN_W-1:0]   c2_q, c3_q, c4_q, c5_q, c6_q;
  logic [CHAN_W-1:0]   m3_q, m4_q, m5_q, m6_q;
  sector_e             sec4_q, sec5_q, sec6_q;
  hue_info_t           info3;
  logic [PROD_W-1:0]   prod4_q;
  logic [CHAN_W-1:0]   x6;
  logic [CHAN_W-1:0]   r7, g7, b7;
  logic [CHAN_W-1:0]   red_d, green_d, blue_d;
  logic [CHAN_W-1:0]   red_q, green_q, blue_q;

  assign busy_o = 1'b0;

  // Valid bits travel with the data
  assign vld_d = {vld_q[DEPTH-2:0], start_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Hue path, stages 1..3
  hsvrgb_hue u_hue (
    .clk_i  (clk_i),
    .hue_i  (hue_i),
    .info_o (info3)
  );

  // Stage 1: clamp and chroma product
  assign s_cl = clamp_one(saturation_i);
  assign v_cl = clamp_one(brightness_i);

  always_ff @(posedge clk_i) begin
    p1_q <= (2*CHAN_W)'(v_cl) * (2*CHAN_W)'(s_cl);
    v1_q <= v_cl;
  end

  // Stage 2: chroma
  always_ff @(posedge clk_i) begin
    c2_q <= CHAN_W'(p1_q >> FRACTION_BITS);
    v2_q <= v1_q;
  end

  // Stage 3: offset m = v - c
  always_ff @(posedge clk_i) begin
    c3_q <= c2_q;
    m3_q <= v2_q - c2_q;
  end

  // Stage 4: c * weight
  always_ff @(posedge clk_i) begin
    prod4_q <= PROD_W'(c3_q) * PROD_W'(info3.weight);
    c4_q    <= c3_q;
    m4_q    <= m3_q;
    sec4_q  <= info3.sector;
  end

  // Stages 5..6: x = floor(c * weight / sector width)
  hsvrgb_div u_div (
    .clk_i  (clk_i),
    .prod_i (prod4_q),
    .quo_o  (x6)
  );

  always_ff @(posedge clk_i) begin
    c5_q   <= c4_q;
    m5_q   <= m4_q;
    sec5_q <= sec4_q;
    c6_q   <= c5_q;
    m6_q   <= m5_q;
    sec6_q <= sec5_q;
  end

  // Stage 7: route c and x by sector, add m
  always_comb begin
    r7 = '0;
    g7 = '0;
    b7 = '0;
    unique case (sec6_q)
      SEC_RED_YELLOW:   begin r7 = c6_q; g7 = x6;   end
      SEC_YELLOW_GREEN: begin r7 = x6;   g7 = c6_q; end
      SEC_GREEN_CYAN:   begin g7 = c6_q; b7 = x6;   end
      SEC_CYAN_BLUE:    begin g7 = x6;   b7 = c6_q; end
      SEC_BLUE_MAGENTA: begin r7 = x6;   b7 = c6_q; end
      default:          begin r7 = c6_q; b7 = x6;   end
    endcase
    red_d   = r7 + m6_q;
    green_d = g7 + m6_q;
    blue_d  = b7 + m6_q;
  end

  always_ff @(posedge clk_i) begin
    red_q   <= red_d;
    green_q <= green_d;
    blue_q  <= blue_d;
  end

  assign valid_o = vld_q[DEPTH-1];
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

`default_nettype wire

[sv/hsvrgb_hue.sv]
// ----------------------------------------------------------------------------
// HSV to RGB hue path
// Three register stages: reciprocal quotient, modulo 360 fixup, sector/weight.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_hue import hsvrgb_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [HUE_W-1:0] hue_i,
  output hue_info_t             info_o
);

  localparam int unsigned HP_W = HUE_W + HUE_RECIP_W;

  logic [HUE_W-1:0]     hue1_q;
  logic [HUE_QUO_W-1:0] quo1_q;
  logic [HP_W-1:0]      hue_prod;
  logic [HUE_W-1:0]     rem2;
  logic [HM_W-1:0]      hm2_d, hm2_q;
  logic [4:0]           ge3;
  logic [HM_W-1:0]      base3;
  logic [HM_W-1:0]      t3;
  logic                 odd3;
  hue_info_t            info3_d, info3_q;

  // Stage 1: quotient estimate by reciprocal multiply
  assign hue_prod = HP_W'(hue_i) * HP_W'(HUE_RECIP);

  always_ff @(posedge clk_i) begin
    hue1_q <= hue_i;
    quo1_q <= HUE_QUO_W'(hue_prod >> HUE_SHIFT);
  end

  // Stage 2: remainder with one correction step
  always_comb begin
    rem2 = hue1_q - HUE_W'(quo1_q) * HUE_W'(HUE_FULL);
    if (rem2 >= HUE_W'(HUE_FULL)) begin
      hm2_d = HM_W'(rem2 - HUE_W'(HUE_FULL));
    end else begin
      hm2_d = HM_W'(rem2);
    end
  end

  always_ff @(posedge clk_i) begin
    hm2_q <= hm2_d;
  end

  // Stage 3: sector from threshold compares, triangle weight
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      ge3[k] = (hm2_q >= HM_W'((k + 1) * HUE_SECTOR));
    end
    odd3 = ^ge3;
    if (ge3[3]) begin
      base3 = HM_W'(2 * HUE_DOUBLE);
    end else if (ge3[1]) begin
      base3 = HM_W'(HUE_DOUBLE);
    end else begin
      base3 = '0;
    end
    t3 = hm2_q - base3;
    if (odd3) begin
      info3_d.weight = WGT_W'(HM_W'(HUE_DOUBLE) - t3);
    end else begin
      info3_d.weight = WGT_W'(t3);
    end
    if (ge3[4]) begin
      info3_d.sector = SEC_MAGENTA_RED;
    end else if (ge3[3]) begin
      info3_d.sector = SEC_BLUE_MAGENTA;
    end else if (ge3[2]) begin
      info3_d.sector = SEC_CYAN_BLUE;
    end else if (ge3[1]) begin
      info3_d.sector = SEC_GREEN_CYAN;
    end else if (ge3[0]) begin
      info3_d.sector = SEC_YELLOW_GREEN;
    end else begin
      info3_d.sector = SEC_RED_YELLOW;
    end
  end

  always_ff @(posedge clk_i) begin
    info3_q <= info3_d;
  end

  assign info_o = info3_q;

endmodule

`default_nettype wire

[sv/hsvrgb_div.sv]
// ----------------------------------------------------------------------------
// HSV to RGB sector divider
// Two register stages: floor(prod / sector width) by reciprocal and fixup.
// ----------------------------------------------------------------------------
`default_nettype none

module hsvrgb_div import hsvrgb_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic [PROD_W-1:0] prod_i,
  output logic      [CHAN_W-1:0] quo_o
);

  localparam int unsigned DP_W = PROD_W + DIV_RECIP_W;

  logic [DP_W-1:0]   div_prod;
  logic [PROD_W-1:0] prod1_q;
  logic [CHAN_W-1:0] quo1_q;
  logic [PROD_W-1:0] rem2;
  logic [CHAN_W-1:0] quo2_d, quo2_q;

  // Stage 1: estimate, exact or one low
  assign div_prod = DP_W'(prod_i) * DP_W'(DIV_RECIP);

  always_ff @(posedge clk_i) begin
    prod1_q <= prod_i;
    quo1_q  <= CHAN_W'(div_prod >> PROD_W);
  end

  // Stage 2: remainder check and increment
  always_comb begin
    rem2 = prod1_q - PROD_W'(quo1_q) * PROD_W'(HUE_SECTOR);
    if (rem2 >= PROD_W'(HUE_SECTOR)) begin
      quo2_d = quo1_q + CHAN_W'(1);
    end else begin
      quo2_d = quo1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quo2_q <= quo2_d;
  end

  assign quo_o = quo2_q;

endmodule

`default_nettype wire
